FILE: hw/rtl/vlpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vlpd_pkg;

  // Longest payload a header may announce
  localparam int unsigned MAX_PAYLOAD_BYTES = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 3;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_LEN_ERR = 1'b1;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [COUNT_W-1:0] bytes_left;
    logic [VALUE_W-1:0] accumulator;
    logic               want_sign;
    logic               first_payload;
  } vlpd_state_t;

  // One decoded result
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } vlpd_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vlpd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vlpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [vlpd_pkg::BYTE_W-1:0]  in_byte;
  logic                         signed_mode;

  modport source (output valid, output in_byte, output signed_mode, input ready);
  modport sink   (input valid, input in_byte, input signed_mode, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vlpd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vlpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [vlpd_pkg::VALUE_W-1:0] value;
  logic                         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vlpd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// Decode one byte against the current state: next state and an optional result
module vlpd_decode (
  input  wire logic [vlpd_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                        sgn_i,
  input  wire vlpd_pkg::vlpd_state_t       state_i,
  output vlpd_pkg::vlpd_state_t            state_o,
  output logic                             emit_o,
  output vlpd_pkg::vlpd_result_t           result_o
);

  logic [6:0]                      len;
  logic [vlpd_pkg::VALUE_W-1:0]    base;
  logic [vlpd_pkg::VALUE_W-1:0]    acc_shift;
  logic [vlpd_pkg::COUNT_W-1:0]    left_dec;

  assign len       = byte_i[6:0];
  assign left_dec  = state_i.bytes_left - vlpd_pkg::COUNT_W'(1);

  // Seed the accumulator with sign fill on the first payload byte
  always_comb begin
    if (state_i.first_payload) begin
      base = (state_i.want_sign && byte_i[7]) ? '1 : '0;
    end else begin
      base = state_i.accumulator;
    end
  end

  assign acc_shift = {base[vlpd_pkg::VALUE_W-vlpd_pkg::BYTE_W-1:0], byte_i};

  always_comb begin
    state_o         = state_i;
    emit_o          = 1'b0;
    result_o.value  = '0;
    result_o.status = vlpd_pkg::STATUS_OK;
    if (state_i.bytes_left == '0) begin
      // Header byte
      if (!byte_i[7]) begin
        emit_o         = 1'b1;
        result_o.value = {{(vlpd_pkg::VALUE_W-7){sgn_i & byte_i[6]}}, len};
      end else if (len == '0) begin
        emit_o = 1'b1;
      end else if (len > 7'(vlpd_pkg::MAX_PAYLOAD_BYTES)) begin
        emit_o          = 1'b1;
        result_o.status = vlpd_pkg::STATUS_LEN_ERR;
      end else begin
        state_o.bytes_left    = len[vlpd_pkg::COUNT_W-1:0];
        state_o.accumulator   = '0;
        state_o.want_sign     = sgn_i;
        state_o.first_payload = 1'b1;
      end
    end else begin
      // Payload byte: shift in big-endian
      state_o.accumulator   = acc_shift;
      state_o.first_payload = 1'b0;
      state_o.bytes_left    = left_dec;
      if (left_dec == '0) begin
        emit_o         = 1'b1;
        result_o.value = acc_shift;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/varint_length_prefixed_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                      Handshake
// in_chan   in   in_byte[7:0], signed_mode    valid/ready
// out_chan  out  value[31:0], status          valid/ready
//
// One byte per cycle while no result stalls; a result goes through the byte register, then the result register.
// The byte register feeds the decode logic, which updates state and loads the result register.
// Reset clears the byte and result valids and returns the decoder to header wait.
// A stalled result holds the byte register; input ready drops only then.
module varint_length_prefixed_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  vlpd_in_if.sink   in_chan,
  vlpd_out_if.source out_chan
);

  logic                          in_valid_r;
  logic [vlpd_pkg::BYTE_W-1:0]   byte_r;
  logic                          sgn_r;
  vlpd_pkg::vlpd_state_t         state_r;
  vlpd_pkg::vlpd_state_t         state_nxt;
  logic                          emit;
  vlpd_pkg::vlpd_result_t        result;
  logic                          out_valid_r;
  vlpd_pkg::vlpd_result_t        out_r;
  logic                          advance;

  vlpd_decode u_decode (
    .byte_i   (byte_r),
    .sgn_i    (sgn_r),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .emit_o   (emit),
    .result_o (result)
  );

  // Move the held byte on unless its result would hit a full, stalled output
  assign advance       = in_valid_r && (!emit || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  // Capture incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.in_byte;
      sgn_r  <= in_chan.signed_mode;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r <= result;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_r.value;
  assign out_chan.status = out_r.status;

  // Payload count never exceeds the longest legal length
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bytes_left <= vlpd_pkg::COUNT_W'(vlpd_pkg::MAX_PAYLOAD_BYTES))
    else $error("bytes_left above maximum payload length");

  // First-payload flag only while payload bytes are expected
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.first_payload |-> state_r.bytes_left != '0)
    else $error("first_payload set while waiting for header");

  // Length errors always carry a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == vlpd_pkg::STATUS_LEN_ERR) |-> out_r.value == '0)
    else $error("length error with nonzero value");

  // A held byte leaves the decoder state untouched
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> $stable(state_r))
    else $error("state changed while byte stalled");

  // A stalled result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(advance && emit))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
